/* hw/rtl/fktl_pkg.sv */
// Package for the connection key table: beat types, status codes and field widths.
// Used by flow_key_table_lookup_insert_top; it depends on nothing else.
package fktl_pkg;

    localparam int IP_W            = 32;
    localparam int PORT_W          = 16;
    localparam int SLOT_W          = 5;
    localparam int LIVE_W          = 6;
    localparam int TABLE_SLOTS_DEF = 32;

    typedef enum logic [2:0] {
        ST_FOUND     = 3'd0,
        ST_INSERTED  = 3'd1,
        ST_FULL      = 3'd2,
        ST_ZERO_KEY  = 3'd3,
        ST_REMOVED   = 3'd4,
        ST_NOT_FOUND = 3'd5
    } status_t;

    typedef enum logic {
        ACT_LOOKUP = 1'b0,
        ACT_REMOVE = 1'b1
    } action_t;

    typedef struct packed {
        action_t                 action;
        logic [IP_W-1:0]         ip;
        logic [PORT_W-1:0]       port;
    } req_beat_t;

    typedef struct packed {
        status_t                 status;
        logic [SLOT_W-1:0]       slot;
        logic [LIVE_W-1:0]       live_count;
    } rsp_beat_t;

endpackage

/* hw/rtl/flow_key_table_lookup_insert_top.sv */
// Connection key table with lookup, insert on miss and remove, top level.
// Depends on fktl_pkg for the beat types, the status codes and the field widths.
//
//   Channel  Direction  Handshake             Beat
//   req      in         req_valid/req_stall   req_beat_t: action, ip, port
//   rsp      out        rsp_valid/rsp_stall   rsp_beat_t: status, slot, live_count
//
// A request scans every slot, one read per slot on a single read port and
// comparator through the registered read, then writes back in S_WRITE and
// loads the response register in S_RESULT. Only once it is back in S_IDLE is
// the next request taken. A zero key lookup skips the scan and goes from
// S_IDLE straight to S_WRITE. After reset a clearing pass writes every entry
// invalid, during which req_stall stays high.
// A stalled response waits in its register while the next request is already
// accepted and scanned; that request's result then waits in S_RESULT, with
// req_stall high, until the register frees up.
module flow_key_table_lookup_insert_top
    import fktl_pkg::*;
#(
    parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  req_beat_t req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_beat_t rsp
);

    // Index width addresses every slot; the count and issue counter also hold
    // TABLE_SLOTS itself.
    localparam int IDX_W   = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CNT_W   = $clog2(TABLE_SLOTS + 1);
    localparam int KEY_W   = IP_W + PORT_W;
    localparam int ENTRY_W = KEY_W + 1;

    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(TABLE_SLOTS - 1);
    localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(TABLE_SLOTS);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_WRITE,
        S_RESULT
    } state_t;

    // Each memory word is {valid, ip, port}.
    logic [ENTRY_W-1:0] key_mem [TABLE_SLOTS];
    logic [ENTRY_W-1:0] rdata_reg;

    state_t             state_reg,      state_next;
    logic [CNT_W-1:0]   iss_reg,        iss_next;
    logic               chk_vld_reg,    chk_vld_next;
    logic [IDX_W-1:0]   chk_idx_reg,    chk_idx_next;
    req_beat_t          key_reg,        key_next;
    logic               hit_found_reg,  hit_found_next;
    logic [IDX_W-1:0]   hit_idx_reg,    hit_idx_next;
    logic               free_found_reg, free_found_next;
    logic [IDX_W-1:0]   free_idx_reg,   free_idx_next;
    logic [CNT_W-1:0]   count_reg,      count_next;
    status_t            res_status_reg, res_status_next;
    logic [IDX_W-1:0]   res_slot_reg,   res_slot_next;
    logic               rsp_valid_reg,  rsp_valid_next;
    rsp_beat_t          rsp_reg,        rsp_next;

    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic [ENTRY_W-1:0] mem_wdata;
    logic [IDX_W-1:0]   mem_raddr;
    logic               key_match;
    logic               entry_free;
    logic               zero_key;

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign mem_raddr  = iss_reg[IDX_W-1:0];
    assign key_match  = rdata_reg[ENTRY_W-1] &&
                        (rdata_reg[KEY_W-1:0] == {key_reg.ip, key_reg.port});
    assign entry_free = !rdata_reg[ENTRY_W-1];
    assign zero_key   = (req.ip == '0) || (req.port == '0);

    // Key memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            key_mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= key_mem[mem_raddr];
    end

    always_comb
    begin
        state_next      = state_reg;
        iss_next        = iss_reg;
        chk_vld_next    = 1'b0;
        chk_idx_next    = chk_idx_reg;
        key_next        = key_reg;
        hit_found_next  = hit_found_reg;
        hit_idx_next    = hit_idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        count_next      = count_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        rsp_valid_next  = rsp_valid_reg;
        rsp_next        = rsp_reg;
        mem_we          = 1'b0;
        mem_waddr       = iss_reg[IDX_W-1:0];
        mem_wdata       = '0;

        // The response register drains independently of the sequencer.
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we = 1'b1;
                if (iss_reg[IDX_W-1:0] == LAST_IDX)
                begin
                    iss_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    iss_next = iss_reg + 1'b1;
                end
            end

            S_IDLE:
            begin
                if (req_valid)
                begin
                    key_next        = req;
                    hit_found_next  = 1'b0;
                    free_found_next = 1'b0;
                    iss_next        = '0;
                    // A zero key lookup is rejected without a scan.
                    if (req.action == ACT_LOOKUP && zero_key)
                    begin
                        state_next = S_WRITE;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                if (iss_reg != SLOTS_CNT)
                begin
                    chk_vld_next = 1'b1;
                    chk_idx_next = iss_reg[IDX_W-1:0];
                    iss_next     = iss_reg + 1'b1;
                end
                if (chk_vld_reg)
                begin
                    if (key_match && !hit_found_reg)
                    begin
                        hit_found_next = 1'b1;
                        hit_idx_next   = chk_idx_reg;
                    end
                    if (entry_free && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = chk_idx_reg;
                    end
                    if (chk_idx_reg == LAST_IDX)
                    begin
                        state_next = S_WRITE;
                    end
                end
            end

            S_WRITE:
            begin
                res_slot_next = '0;
                state_next    = S_RESULT;
                if (key_reg.action == ACT_LOOKUP)
                begin
                    if (key_reg.ip == '0 || key_reg.port == '0)
                    begin
                        res_status_next = ST_ZERO_KEY;
                    end
                    else if (hit_found_reg)
                    begin
                        res_status_next = ST_FOUND;
                        res_slot_next   = hit_idx_reg;
                    end
                    else if (free_found_reg)
                    begin
                        res_status_next = ST_INSERTED;
                        res_slot_next   = free_idx_reg;
                        mem_we          = 1'b1;
                        mem_waddr       = free_idx_reg;
                        mem_wdata       = {1'b1, key_reg.ip, key_reg.port};
                        count_next      = count_reg + 1'b1;
                    end
                    else
                    begin
                        res_status_next = ST_FULL;
                    end
                end
                else
                begin
                    if (hit_found_reg)
                    begin
                        res_status_next = ST_REMOVED;
                        res_slot_next   = hit_idx_reg;
                        mem_we          = 1'b1;
                        mem_waddr       = hit_idx_reg;
                        mem_wdata       = '0;
                        if (count_reg != '0)
                        begin
                            count_next = count_reg - 1'b1;
                        end
                    end
                    else
                    begin
                        res_status_next = ST_NOT_FOUND;
                    end
                end
            end

            S_RESULT:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next      = 1'b1;
                    rsp_next.status     = res_status_reg;
                    rsp_next.slot       = SLOT_W'(res_slot_reg);
                    rsp_next.live_count = LIVE_W'(count_reg);
                    state_next          = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            iss_reg        <= '0;
            chk_vld_reg    <= 1'b0;
            chk_idx_reg    <= '0;
            key_reg        <= '0;
            hit_found_reg  <= 1'b0;
            hit_idx_reg    <= '0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
            count_reg      <= '0;
            res_status_reg <= ST_FOUND;
            res_slot_reg   <= '0;
            rsp_valid_reg  <= 1'b0;
            rsp_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            iss_reg        <= iss_next;
            chk_vld_reg    <= chk_vld_next;
            chk_idx_reg    <= chk_idx_next;
            key_reg        <= key_next;
            hit_found_reg  <= hit_found_next;
            hit_idx_reg    <= hit_idx_next;
            free_found_reg <= free_found_next;
            free_idx_reg   <= free_idx_next;
            count_reg      <= count_next;
            res_status_reg <= res_status_next;
            res_slot_reg   <= res_slot_next;
            rsp_valid_reg  <= rsp_valid_next;
            rsp_reg        <= rsp_next;
        end
    end

endmodule

/* test/fktl_checker.sv */
// Response checker for the connection key table: watches the req and rsp channels,
// predicts every response from its own copy of the table and compares field by field.
// Depends on fktl_pkg for the beat types, the status codes and the field widths.
`timescale 1ns / 100ps

module fktl_checker
    import fktl_pkg::*;
#(
    parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    input  logic      req_stall,
    input  req_beat_t req,
    input  logic      rsp_valid,
    input  logic      rsp_stall,
    input  rsp_beat_t rsp,
    output int        mismatch_count,
    output int        awaiting
);

    logic [IP_W-1:0]        slot_ip   [TABLE_SLOTS];
    logic [PORT_W-1:0]      slot_port [TABLE_SLOTS];
    logic [TABLE_SLOTS-1:0] slot_used = '0;
    int unsigned            used_total = 0;
    rsp_beat_t              pending_rsp[$];

    initial
    begin
        mismatch_count = 0;
        awaiting = 0;
    end

    // Applies one request to the shadow table and returns the response it must give.
    function automatic rsp_beat_t apply_request(req_beat_t r);
        rsp_beat_t res;
        int        hit;
        int        spare;
        hit = -1;
        spare = -1;
        res.status = ST_NOT_FOUND;
        res.slot = '0;
        for (int i = 0; i < TABLE_SLOTS; i++)
        begin
            if (hit < 0 && slot_used[i] && slot_ip[i] == r.ip && slot_port[i] == r.port)
                hit = i;
            if (spare < 0 && !slot_used[i])
                spare = i;
        end
        if (r.action == ACT_LOOKUP)
        begin
            if (r.ip == '0 || r.port == '0)
                res.status = ST_ZERO_KEY;
            else if (hit >= 0)
            begin
                res.status = ST_FOUND;
                res.slot = SLOT_W'(hit);
            end
            else if (spare < 0)
                res.status = ST_FULL;
            else
            begin
                slot_ip[spare] = r.ip;
                slot_port[spare] = r.port;
                slot_used[spare] = 1'b1;
                used_total++;
                res.status = ST_INSERTED;
                res.slot = SLOT_W'(spare);
            end
        end
        else if (hit >= 0)
        begin
            slot_used[hit] = 1'b0;
            if (used_total > 0)
                used_total--;
            res.status = ST_REMOVED;
            res.slot = SLOT_W'(hit);
        end
        res.live_count = LIVE_W'(used_total);
        return res;
    endfunction

    always @(posedge clk)
    begin : watch
        rsp_beat_t want;
        if (!rst_n)
        begin
            slot_used = '0;
            used_total = 0;
            pending_rsp.delete();
        end
        else
        begin
            // The response side is handled first so that a request taken at the
            // same edge can never stand in for a response that came too early.
            if (rsp_valid && !rsp_stall)
            begin
                if (pending_rsp.size() == 0)
                begin
                    $error("unexpected response beat: status %0d slot %0d live_count %0d",
                           rsp.status, rsp.slot, rsp.live_count);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_rsp.pop_front();
                    if (rsp.status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, rsp.status);
                        mismatch_count++;
                    end
                    if (rsp.slot !== want.slot)
                    begin
                        $error("slot: expected %0d, actual %0d", want.slot, rsp.slot);
                        mismatch_count++;
                    end
                    if (rsp.live_count !== want.live_count)
                    begin
                        $error("live_count: expected %0d, actual %0d",
                               want.live_count, rsp.live_count);
                        mismatch_count++;
                    end
                end
            end
            if (req_valid && !req_stall)
                pending_rsp.push_back(apply_request(req));
        end
        awaiting <= pending_rsp.size();
    end

endmodule

/* test/tb.sv */
// Testbench top for the connection key table: clock, reset, request stimulus,
// response stalls and the final verdict. Depends on fktl_pkg, the block
// flow_key_table_lookup_insert_top and the fktl_checker module.
`timescale 1ns / 100ps

module tb
    import fktl_pkg::*;
();

    // Keys in the working set of one round. It is larger than the table so that
    // the table fills up and lookups of new keys report a full table.
    localparam int POOL_KEYS = 40;
    localparam int ROUNDS    = 4;
    localparam int MIXED_OPS = 80;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      req_valid;
    logic      req_stall;
    req_beat_t req;
    logic      rsp_valid;
    logic      rsp_stall;
    rsp_beat_t rsp;

    int        mismatch_count;
    int        awaiting;
    int        sent_count = 0;
    int        taken_count = 0;

    logic [IP_W-1:0]   pool_ip   [POOL_KEYS];
    logic [PORT_W-1:0] pool_port [POOL_KEYS];
    req_beat_t         stray_keys[$];

    always #10 clk = ~clk;

    flow_key_table_lookup_insert_top #(
        .TABLE_SLOTS(TABLE_SLOTS_DEF)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // The checker sits beside the block and sees exactly the same handshakes.
    fktl_checker #(
        .TABLE_SLOTS(TABLE_SLOTS_DEF)
    ) table_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .req            (req),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .rsp            (rsp),
        .mismatch_count (mismatch_count),
        .awaiting       (awaiting)
    );

    // Offers one request beat and returns at the edge where it is taken.
    // Before the beat the sender idles for a randomly drawn gap, possibly none, except in every
    // fourth stretch of 32 beats, where it sends back to back. When there is no
    // gap, valid simply stays high, so it is never lowered and raised in one step.
    task automatic send_request(input action_t act, input logic [IP_W-1:0] ip,
                                input logic [PORT_W-1:0] port);
        int gap;
        if (((sent_count / 32) % 4) == 3)
            gap = 0;
        else
            gap = $urandom_range(0, 4);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req <= '{action: act, ip: ip, port: port};
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        sent_count++;
    endtask

    // Request side: a short directed part, then rounds of random traffic on a
    // working set of keys. Each round fills the table past full, mixes lookups
    // and removes, and finally drains every key it may have stored.
    initial
    begin : stimulus
        int                pick;
        int                k;
        logic [IP_W-1:0]   rand_ip;
        logic [PORT_W-1:0] rand_port;
        req_beat_t         stray;

        rst_n <= 1'b0;
        req_valid <= 1'b0;
        req <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Zero keys are rejected on lookup, whichever part is zero.
        send_request(ACT_LOOKUP, 32'h0, 16'd80);
        send_request(ACT_LOOKUP, 32'hC0A8_0001, 16'h0);
        send_request(ACT_LOOKUP, 32'h0, 16'h0);
        // Removing from an empty table, and removing a zero key, find nothing.
        send_request(ACT_REMOVE, 32'hC0A8_0001, 16'd443);
        send_request(ACT_REMOVE, 32'h0, 16'h0);
        // All-ones key goes to slot 0 and is then found there.
        send_request(ACT_LOOKUP, 32'hFFFF_FFFF, 16'hFFFF);
        send_request(ACT_LOOKUP, 32'hFFFF_FFFF, 16'hFFFF);
        // Keys that share only the address or only the port are distinct.
        send_request(ACT_LOOKUP, 32'h1, 16'h1);
        send_request(ACT_LOOKUP, 32'hFFFF_FFFF, 16'h1);
        send_request(ACT_LOOKUP, 32'h1, 16'hFFFF);
        send_request(ACT_LOOKUP, 32'h1, 16'h1);
        // Slot 0 can be removed; a second remove of the same key misses.
        send_request(ACT_REMOVE, 32'hFFFF_FFFF, 16'hFFFF);
        send_request(ACT_REMOVE, 32'hFFFF_FFFF, 16'hFFFF);
        // The next insert reuses the lowest free slot, which is 0 again.
        send_request(ACT_LOOKUP, 32'h0A00_0001, 16'd443);
        send_request(ACT_REMOVE, 32'h1, 16'h1);
        send_request(ACT_LOOKUP, 32'h0A00_0001, 16'd443);
        send_request(ACT_REMOVE, 32'h1, 16'hFFFF);
        send_request(ACT_REMOVE, 32'hFFFF_FFFF, 16'h1);
        send_request(ACT_REMOVE, 32'h0A00_0001, 16'd443);

        for (int round = 0; round < ROUNDS; round++)
        begin
            // New working set. Some keys share an address with their neighbor,
            // some share a port, so a match must compare both parts.
            for (int i = 0; i < POOL_KEYS; i++)
            begin
                pool_ip[i] = $urandom;
                pool_port[i] = PORT_W'($urandom_range(1, 16'hFFFF));
                if (i % 4 == 1)
                    pool_ip[i] = pool_ip[i-1];
                else if (i % 4 == 2)
                    pool_port[i] = pool_port[i-1];
                if (pool_ip[i] == '0)
                    pool_ip[i] = 32'h1;
            end

            // Fill the table in order; the last keys find it full.
            for (int i = 0; i < POOL_KEYS; i++)
                send_request(ACT_LOOKUP, pool_ip[i], pool_port[i]);

            for (int n = 0; n < MIXED_OPS; n++)
            begin
                pick = $urandom_range(0, 99);
                k = $urandom_range(0, POOL_KEYS - 1);
                rand_ip = $urandom;
                rand_port = PORT_W'($urandom_range(0, 16'hFFFF));
                if (pick < 50)
                    send_request(ACT_LOOKUP, pool_ip[k], pool_port[k]);
                else if (pick < 78)
                    send_request(ACT_REMOVE, pool_ip[k], pool_port[k]);
                else if (pick < 86)
                    send_request(ACT_REMOVE, rand_ip, rand_port);
                else if (pick < 94)
                begin
                    if ($urandom_range(0, 1) == 1)
                        send_request(ACT_LOOKUP, '0, rand_port);
                    else
                        send_request(ACT_LOOKUP, rand_ip, '0);
                end
                else
                begin
                    // A stray key may be stored, so it is kept for the drain.
                    if (rand_port == '0)
                        rand_port = 16'h1;
                    stray_keys.push_back('{action: ACT_REMOVE, ip: rand_ip, port: rand_port});
                    send_request(ACT_LOOKUP, rand_ip, rand_port);
                end
            end

            // Drain the table so the next round starts from empty.
            for (int i = 0; i < POOL_KEYS; i++)
                send_request(ACT_REMOVE, pool_ip[i], pool_port[i]);
            while (stray_keys.size() > 0)
            begin
                stray = stray_keys.pop_front();
                send_request(ACT_REMOVE, stray.ip, stray.port);
            end
        end

        req_valid <= 1'b0;
        // One edge lets the checker count the last request before we look.
        @(posedge clk);
        while (awaiting != 0)
            @(posedge clk);
        // Any extra response beat would show during this wait.
        repeat (100) @(posedge clk);

        if (mismatch_count == 0 && awaiting == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Response side. For each beat the receiver draws a random hold, possibly none.
    // With a hold it raises stall right away, waits for a response beat to show
    // up and keeps it waiting for the drawn hold before taking it.
    // Every fourth stretch of 32 beats it takes responses at once. Once, after the
    // hundredth response, it holds the next beat off while the sender keeps
    // offering requests, so the block fills up and stalls its input.
    initial
    begin : response_sink
        int hold;
        rsp_stall <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (taken_count == 100)
                hold = 300;
            else if (((taken_count / 32) % 4) == 2)
                hold = 0;
            else
                hold = $urandom_range(0, 4);
            if (hold > 0)
            begin
                rsp_stall <= 1'b1;
                @(posedge clk);
                while (!rsp_valid)
                    @(posedge clk);
                repeat (hold - 1) @(posedge clk);
            end
            rsp_stall <= 1'b0;
            @(posedge clk);
            while (!rsp_valid)
                @(posedge clk);
            taken_count++;
        end
    end

    // A correct run takes well under a millisecond; this limit is several times that.
    initial
    begin : watchdog
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
